### hw/rtl/ising_annealing_step_core_macros.svh
// Assertion helpers for the annealing step core.
`ifndef ISING_ANNEALING_STEP_CORE_MACROS_SVH
`define ISING_ANNEALING_STEP_CORE_MACROS_SVH

// Check a property while out of reset.
`define IASC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define IASC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/iasc_pkg.sv
package iasc_pkg;

  localparam int MAX_SPINS_DEF       = 64;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam logic [31:0] INIT_TEMP_RST  = 32'd65536;
  localparam logic [16:0] COOLING_RST    = 17'd65208;
  localparam logic [31:0] STEP_LIMIT_RST = 32'd1000;
  localparam logic [6:0]  ACTIVE_RST     = 7'd64;

  typedef enum logic [1:0] {
    CFG_INIT_TEMP  = 2'd0,
    CFG_COOLING    = 2'd1,
    CFG_STEP_LIMIT = 2'd2,
    CFG_ACTIVE     = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    OP_WR_COUPLING = 3'd0,
    OP_WR_FIELD    = 3'd1,
    OP_WR_SPIN     = 3'd2,
    OP_STEP        = 3'd3,
    OP_START       = 3'd4,
    OP_READ        = 3'd5
  } op_t;

  typedef struct packed {
    logic [31:0] init_temp;
    logic [16:0] cooling;
    logic [31:0] step_limit;
    logic [6:0]  active;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] weight;
    logic               spin_up;
    logic [15:0]        rnd;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [5:0]         spin_index;
    logic               spin_state;
    logic               flipped;
    logic signed [23:0] energy_change;
    logic signed [27:0] total_energy;
    logic               done;
  } result_t;

  // round(65536*exp(-idx/32)) clamped to 65535, in Q62 integer arithmetic
  function automatic logic [15:0] exp_val(input int unsigned idx);
    logic [63:0]  term;
    logic [63:0]  pos;
    logic [63:0]  neg;
    logic [63:0]  r;
    logic [63:0]  x;
    logic [63:0]  v;
    logic [127:0] p;
    term = 64'h4000_0000_0000_0000;
    pos  = term;
    neg  = 64'd0;
    term = term / 32;  neg = neg + term;
    term = term / 64;  pos = pos + term;
    term = term / 96;  neg = neg + term;
    term = term / 128; pos = pos + term;
    term = term / 160; neg = neg + term;
    term = term / 192; pos = pos + term;
    term = term / 224; neg = neg + term;
    term = term / 256; pos = pos + term;
    term = term / 288; neg = neg + term;
    term = term / 320; pos = pos + term;
    term = term / 352; neg = neg + term;
    term = term / 384; pos = pos + term;
    term = term / 416; neg = neg + term;
    term = term / 448; pos = pos + term;
    term = term / 480; neg = neg + term;
    term = term / 512; pos = pos + term;
    term = term / 544; neg = neg + term;
    term = term / 576; pos = pos + term;
    term = term / 608; neg = neg + term;
    term = term / 640; pos = pos + term;
    r = pos - neg;
    x = 64'h4000_0000_0000_0000;
    for (int unsigned k = 0; k < idx; k++) begin
      p = {64'd0, x} * {64'd0, r};
      x = p[125:62];
    end
    v = (x + 64'h0000_2000_0000_0000) >> 46;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

### hw/rtl/iasc_front.sv
module iasc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_op,
  input  logic [5:0]          in_row,
  input  logic [5:0]          in_col,
  input  logic signed [15:0]  in_weight,
  input  logic                in_spin_up,
  input  logic [15:0]         in_uniform_random,
  output iasc_pkg::item_t     q_item,
  output logic                q_valid,
  input  logic                q_pop
);
  import iasc_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  item_t      cls;

  // classify: unused codes act as read spin
  always_comb begin
    cls.row     = in_row;
    cls.col     = in_col;
    cls.weight  = in_weight;
    cls.spin_up = in_spin_up;
    cls.rnd     = in_uniform_random;
    unique case (in_op)
      3'd0:    cls.op = OP_WR_COUPLING;
      3'd1:    cls.op = OP_WR_FIELD;
      3'd2:    cls.op = OP_WR_SPIN;
      3'd3:    cls.op = OP_STEP;
      3'd4:    cls.op = OP_START;
      default: cls.op = OP_READ;
    endcase
  end

  assign busy    = (count_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### hw/rtl/iasc_back.sv
module iasc_back #(
  parameter int MAX_SPINS       = iasc_pkg::MAX_SPINS_DEF,
  parameter int EXP_TABLE_DEPTH = iasc_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  iasc_pkg::cfg_t    cfg,
  input  iasc_pkg::item_t   q_item,
  input  logic              q_valid,
  output logic              q_pop,
  output iasc_pkg::result_t res
);
  import iasc_pkg::*;

  localparam int SW     = $clog2(MAX_SPINS);
  localparam int CW     = ($clog2(MAX_SPINS + 1) > 7) ? $clog2(MAX_SPINS + 1) : 7;
  localparam int ACC_W  = (16 + 2 * SW + 2 > 30) ? 16 + 2 * SW + 2 : 30;
  localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int BW     = $clog2(IDX_W);
  localparam int CMP_W  = 32 + $clog2(EXP_TABLE_DEPTH + 1);

  localparam logic signed [ACC_W:0] D_MAX = (ACC_W + 1)'(8388607);
  localparam logic signed [ACC_W:0] D_MIN = -(ACC_W + 1)'(8388608);
  localparam logic signed [ACC_W:0] E_MAX = (ACC_W + 1)'(134217727);
  localparam logic signed [ACC_W:0] E_MIN = -(ACC_W + 1)'(134217728);
  localparam logic signed [28:0]    EU_MAX = 29'sd134217727;
  localparam logic signed [28:0]    EU_MIN = -29'sd134217728;
  localparam logic [CMP_W-1:0]      DEPTH_C = CMP_W'(EXP_TABLE_DEPTH);
  localparam logic [CW-1:0]         N_MAX = CW'(MAX_SPINS);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SUM, S_DRAIN, S_DELTA, S_CHECK, S_DIV, S_LOOKUP, S_ACCEPT, S_FINISH
  } state_t;

  state_t                   state_r;
  item_t                    it_r;
  logic [MAX_SPINS-1:0]     spin_r;
  logic [31:0]              temp_r;
  logic signed [27:0]       energy_r;
  logic [31:0]              count_r;
  logic [CW-1:0]            a_r;
  logic [CW-1:0]            b_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     p_valid_r;
  logic                     p_field_r;
  logic                     p_neg_r;
  logic signed [23:0]       delta_r;
  logic                     accept_r;
  logic [CMP_W-1:0]         rem_r;
  logic [IDX_W-1:0]         q_r;
  logic [BW-1:0]            bit_r;
  logic [15:0]              rom_r;
  result_t                  res_r;

  logic signed [15:0] cmem [2**(2 * SW)];
  logic signed [15:0] hmem [MAX_SPINS];
  logic signed [15:0] c_rd_r;
  logic signed [15:0] h_rd_r;
  logic [15:0]        exp_w [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_w[g] = exp_val(g);
  end

  logic [SW-1:0]           row_idx;
  logic                    row_ok;
  logic                    col_ok;
  logic [CW-1:0]           row_ext;
  logic [CW-1:0]           act_ext;
  logic [CW-1:0]           n_eff;
  logic                    spin_cur;
  logic                    is_start;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic                    iss_field;
  logic                    iss_neg;
  logic [SW-1:0]           h_addr;
  logic                    c_we;
  logic                    h_we;
  logic signed [ACC_W-1:0] term_ext;
  logic signed [ACC_W:0]   dfull;
  logic signed [ACC_W:0]   efull;
  logic signed [28:0]      esum;
  logic [CMP_W-1:0]        num;
  logic [CMP_W-1:0]        lim;
  logic [CMP_W-1:0]        dsh;
  logic [48:0]             cool_prod;
  logic [31:0]             temp_cool;
  logic [31:0]             count_inc;

  assign row_idx  = SW'(it_r.row);
  assign row_ext  = CW'(it_r.row);
  assign row_ok   = row_ext < N_MAX;
  assign col_ok   = CW'(it_r.col) < N_MAX;
  assign act_ext  = CW'(cfg.active);
  assign n_eff    = (act_ext > N_MAX) ? N_MAX : act_ext;
  assign spin_cur = row_ok ? spin_r[row_idx] : 1'b0;
  assign is_start = (it_r.op == OP_START);
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign res      = res_r;

  // term addressing: a step walks j against the row, start walks i <= j
  always_comb begin
    if (is_start) begin
      lo        = a_r;
      hi        = b_r;
      iss_field = (a_r == b_r);
      iss_neg   = iss_field ? !spin_r[SW'(a_r)] : (spin_r[SW'(a_r)] ^ spin_r[SW'(b_r)]);
      h_addr    = SW'(a_r);
    end else begin
      lo        = (b_r < row_ext) ? b_r : row_ext;
      hi        = (b_r < row_ext) ? row_ext : b_r;
      iss_field = (b_r == row_ext);
      iss_neg   = iss_field ? 1'b0 : !spin_r[SW'(b_r)];
      h_addr    = row_idx;
    end
  end

  assign c_we = (state_r == S_EXEC) && (it_r.op == OP_WR_COUPLING) && row_ok && col_ok;
  assign h_we = (state_r == S_EXEC) && (it_r.op == OP_WR_FIELD) && row_ok;

  always_ff @(posedge clk) begin
    if (c_we) cmem[{row_idx, SW'(it_r.col)}] <= it_r.weight;
    c_rd_r <= cmem[{SW'(lo), SW'(hi)}];
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[row_idx] <= it_r.weight;
    h_rd_r <= hmem[h_addr];
  end

  always_comb begin
    term_ext  = p_field_r ? ACC_W'(h_rd_r) : ACC_W'(c_rd_r);
    dfull     = spin_cur ? {acc_r, 1'b0} : -{acc_r, 1'b0};
    efull     = -{acc_r[ACC_W-1], acc_r};
    esum      = {energy_r[27], energy_r} + 29'(delta_r);
    num       = CMP_W'({delta_r[22:0], 13'd0});
    lim       = CMP_W'(temp_r) * DEPTH_C;
    dsh       = CMP_W'(temp_r) << bit_r;
    cool_prod = temp_r * cfg.cooling;
    temp_cool = cool_prod[48] ? 32'hFFFF_FFFF : cool_prod[47:16];
    count_inc = count_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      spin_r    <= '0;
      temp_r    <= INIT_TEMP_RST;
      energy_r  <= '0;
      count_r   <= '0;
      p_valid_r <= 1'b0;
      res_r     <= '0;
    end else begin
      res_r.valid <= 1'b0;
      p_valid_r   <= (state_r == S_SUM);
      p_field_r   <= iss_field;
      p_neg_r     <= iss_neg;
      if (p_valid_r) begin
        acc_r <= acc_r + (p_neg_r ? -term_ext : term_ext);
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r    <= q_item;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          acc_r            <= '0;
          a_r              <= '0;
          b_r              <= '0;
          accept_r         <= 1'b0;
          delta_r          <= '0;
          res_r.spin_index <= it_r.row;
          res_r.spin_state <= spin_cur;
          res_r.flipped    <= 1'b0;
          res_r.energy_change <= '0;
          res_r.total_energy  <= energy_r;
          res_r.done       <= (count_r >= cfg.step_limit);
          unique case (it_r.op)
            OP_START: begin
              state_r <= (n_eff == '0) ? S_DRAIN : S_SUM;
            end
            OP_STEP: begin
              if (count_r >= cfg.step_limit) begin
                res_r.valid <= 1'b1;
                state_r     <= S_IDLE;
              end else if (row_ext < n_eff) begin
                state_r <= S_SUM;
              end else begin
                state_r <= S_FINISH;
              end
            end
            OP_WR_SPIN: begin
              if (row_ok) spin_r[row_idx] <= it_r.spin_up;
              res_r.spin_state <= row_ok && it_r.spin_up;
              res_r.valid      <= 1'b1;
              state_r          <= S_IDLE;
            end
            OP_WR_COUPLING, OP_WR_FIELD, OP_READ: begin
              res_r.valid <= 1'b1;
              state_r     <= S_IDLE;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_SUM: begin
          if (b_r == n_eff - CW'(1)) begin
            if (!is_start || a_r == n_eff - CW'(1)) begin
              state_r <= S_DRAIN;
            end else begin
              a_r <= a_r + CW'(1);
              b_r <= a_r + CW'(1);
            end
          end else begin
            b_r <= b_r + CW'(1);
          end
        end
        S_DRAIN: state_r <= S_DELTA;
        S_DELTA: begin
          if (is_start) begin
            if (efull > E_MAX) energy_r <= 28'sh7FF_FFFF;
            else if (efull < E_MIN) energy_r <= -28'sh800_0000;
            else energy_r <= efull[27:0];
            temp_r   <= cfg.init_temp;
            count_r  <= '0;
            res_r.total_energy <= (efull > E_MAX) ? 28'sh7FF_FFFF :
                                  (efull < E_MIN) ? -28'sh800_0000 : efull[27:0];
            res_r.done  <= (cfg.step_limit == 32'd0);
            res_r.valid <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            if (dfull > D_MAX) delta_r <= 24'sh7F_FFFF;
            else if (dfull < D_MIN) delta_r <= -24'sh80_0000;
            else delta_r <= dfull[23:0];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          // negative delta always flips; large index or cold system rejects
          priority if (delta_r[23]) begin
            accept_r <= 1'b1;
            state_r  <= S_FINISH;
          end else if (temp_r == 32'd0 || num >= lim) begin
            state_r <= S_FINISH;
          end else begin
            rem_r   <= num;
            q_r     <= '0;
            bit_r   <= BW'(IDX_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_r >= dsh) begin
            rem_r    <= rem_r - dsh;
            q_r[bit_r] <= 1'b1;
          end
          if (bit_r == '0) state_r <= S_LOOKUP;
          else bit_r <= bit_r - BW'(1);
        end
        S_LOOKUP: begin
          rom_r   <= exp_w[q_r];
          state_r <= S_ACCEPT;
        end
        S_ACCEPT: begin
          accept_r <= (it_r.rnd < rom_r);
          state_r  <= S_FINISH;
        end
        S_FINISH: begin
          if (accept_r) begin
            spin_r[row_idx] <= !spin_cur;
            if (esum > EU_MAX) energy_r <= 28'sh7FF_FFFF;
            else if (esum < EU_MIN) energy_r <= -28'sh800_0000;
            else energy_r <= esum[27:0];
          end
          temp_r  <= temp_cool;
          count_r <= count_inc;
          res_r.spin_state    <= accept_r ? !spin_cur : spin_cur;
          res_r.flipped       <= accept_r;
          res_r.energy_change <= delta_r;
          res_r.total_energy  <= !accept_r ? energy_r :
                                 (esum > EU_MAX) ? 28'sh7FF_FFFF :
                                 (esum < EU_MIN) ? -28'sh800_0000 : esum[27:0];
          res_r.done  <= (count_inc >= cfg.step_limit);
          res_r.valid <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/ising_annealing_step_core.sv
// Channel | Ports                                 | Handshake
// input   | in_op in_row in_col in_weight ...     | start & !busy
// result  | out_spin_index ... out_done_res       | out_valid, one cycle
// config  | cfg_we cfg_index cfg_data             | cfg_we, no wait
// Writes and reads of a spin pass from the queue slot through the item register to the result register.
// Anneal step: the coupling memory walk takes one term per cycle (n active spins),
// then a bit-per-cycle quotient gives the table index unless the check decides.
// Start: walks each pair i <= j of active spins, one coupling or field term per cycle.
// A two-entry queue holds items while the sequencer works; busy marks it full.
// Reset clears spins, energy and step count and reloads temperature; coupling and
// field memories are not cleared. The receiver takes every result as it comes.
module ising_annealing_step_core #(
  parameter int MAX_SPINS       = iasc_pkg::MAX_SPINS_DEF,
  parameter int EXP_TABLE_DEPTH = iasc_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [5:0]         in_row,
  input  logic [5:0]         in_col,
  input  logic signed [15:0] in_weight,
  input  logic               in_spin_up,
  input  logic [15:0]        in_uniform_random,
  output logic               out_valid,
  output logic [5:0]         out_spin_index,
  output logic               out_spin_state,
  output logic               out_flipped,
  output logic signed [23:0] out_energy_change,
  output logic signed [27:0] out_total_energy,
  output logic               out_done_res,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import iasc_pkg::*;

  cfg_t    cfg_r;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_temp  <= INIT_TEMP_RST;
      cfg_r.cooling    <= COOLING_RST;
      cfg_r.step_limit <= STEP_LIMIT_RST;
      cfg_r.active     <= ACTIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_INIT_TEMP:  cfg_r.init_temp  <= cfg_data;
        CFG_COOLING:    cfg_r.cooling    <= cfg_data[16:0];
        CFG_STEP_LIMIT: cfg_r.step_limit <= cfg_data;
        CFG_ACTIVE:     cfg_r.active     <= cfg_data[6:0];
      endcase
    end
  end

  iasc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_weight         (in_weight),
    .in_spin_up        (in_spin_up),
    .in_uniform_random (in_uniform_random),
    .q_item            (q_item),
    .q_valid           (q_valid),
    .q_pop             (q_pop)
  );

  iasc_back #(
    .MAX_SPINS       (MAX_SPINS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .res     (res)
  );

  assign out_valid         = res.valid;
  assign out_spin_index    = res.spin_index;
  assign out_spin_state    = res.spin_state;
  assign out_flipped       = res.flipped;
  assign out_energy_change = res.energy_change;
  assign out_total_energy  = res.total_energy;
  assign out_done_res      = res.done;

endmodule

### hw/rtl/iasc_checker.sv
`include "ising_annealing_step_core_macros.svh"

module iasc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // reset leaves no result pending and the queue open
  `IASC_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (!out_valid && !busy), "reset not clean")
  // the queue fills only on an accepted transaction
  `IASC_ASSERT(a_busy_rise, clk, rst_n, $rose(busy) |-> $past(start), "busy without transaction")
  // no result on the first cycle after reset
  `IASC_ASSERT_ALWAYS(a_no_early_result, clk, out_valid |-> $past(rst_n), "result out of reset")

endmodule

bind ising_annealing_step_core iasc_checker u_iasc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
